// ----- hdl/nrpg_pkg.sv -----
package nrpg_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int PHASE_FRAC_BITS = 16;

    // Configuration register file
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 21;
    localparam int STEP_W      = 21;
    localparam int VOL_W       = 16;
    localparam int PAN_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_STEP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAN       = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MONO      = 2'd3;

    localparam logic [VOL_W-1:0] VOL_UNITY = 16'd32768;

    // Phase holds values below 17 times one
    localparam int PHASE_W = PHASE_FRAC_BITS + 5;
    localparam int CMP_W   = (STEP_W > PHASE_W) ? STEP_W : PHASE_W;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
    localparam logic [CMP_W-1:0]   STEP_MIN  = CMP_W'(1) << (PHASE_FRAC_BITS - 6);
    localparam logic [CMP_W-1:0]   STEP_MAX  = CMP_W'(1) << (PHASE_FRAC_BITS + 4);
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(PHASE_ONE);

    localparam int MAX_OUT = 64;
    localparam int CNT_W   = $clog2(MAX_OUT);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUT - 1);

    // Gain is at most 2^30
    localparam int GAIN_W = 31;
    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic load;
        logic mult;
        logic round;
        logic drop;
        logic adv;
    } t_dp_cmd;

    typedef struct packed {
        logic phase_ge_one;
        logic last;
    } t_dp_status;

endpackage

// ----- hdl/nrpg_ctrl.sv -----
module nrpg_ctrl
    import nrpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MULT  = 4'b0010,
        S_ROUND = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MULT;
                end
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                // phase at or past one: no output for this frame
                if (i_status.phase_ge_one) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.adv = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/nrpg_datapath.sv -----
module nrpg_datapath
    import nrpg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_write,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  t_sample                i_sample_left,
    input  t_sample                i_sample_right,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output t_sample                o_out_left,
    output t_sample                o_out_right
);

    logic [STEP_W-1:0] r_rate_step;
    logic [VOL_W-1:0]  r_volume;
    logic [PAN_W-1:0]  r_pan;
    logic              r_mono;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_step <= STEP_RESET;
            r_volume    <= VOL_UNITY;
            r_pan       <= '0;
            r_mono      <= 1'b0;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_RATE_STEP: r_rate_step <= i_cfg_data[STEP_W-1:0];
                CFG_VOLUME:    r_volume    <= i_cfg_data[VOL_W-1:0];
                CFG_PAN:       r_pan       <= i_cfg_data[PAN_W-1:0];
                CFG_MONO:      r_mono      <= i_cfg_data[0];
                default:       r_mono      <= r_mono;
            endcase
        end
    end

    // Gain terms from the configuration
    logic [VOL_W-1:0]        vol_c;
    logic signed [PAN_W+1:0] pan_ext;
    logic signed [PAN_W+1:0] pl_s;
    logic signed [PAN_W+1:0] pr_s;
    logic [VOL_W-1:0]        pl_c;
    logic [VOL_W-1:0]        pr_c;
    logic [2*VOL_W-1:0]      gl_full;
    logic [2*VOL_W-1:0]      gr_full;
    logic [CMP_W-1:0]        step_ext;
    logic [CMP_W-1:0]        step_c;

    always_comb begin
        vol_c   = (r_volume > VOL_UNITY) ? VOL_UNITY : r_volume;
        pan_ext = {{2{r_pan[PAN_W-1]}}, r_pan};
        pl_s    = $signed({2'b00, VOL_UNITY}) - pan_ext;
        pr_s    = $signed({2'b00, VOL_UNITY}) + pan_ext;
        // clamp pan gains to zero .. unity
        if (pl_s < 0) begin
            pl_c = '0;
        end else if (pl_s > $signed({2'b00, VOL_UNITY})) begin
            pl_c = VOL_UNITY;
        end else begin
            pl_c = pl_s[VOL_W-1:0];
        end
        if (pr_s < 0) begin
            pr_c = '0;
        end else if (pr_s > $signed({2'b00, VOL_UNITY})) begin
            pr_c = VOL_UNITY;
        end else begin
            pr_c = pr_s[VOL_W-1:0];
        end
        gl_full  = vol_c * pl_c;
        gr_full  = vol_c * pr_c;
        step_ext = CMP_W'(r_rate_step);
        if (step_ext < STEP_MIN) begin
            step_c = STEP_MIN;
        end else if (step_ext > STEP_MAX) begin
            step_c = STEP_MAX;
        end else begin
            step_c = step_ext;
        end
    end

    t_sample             r_sl;
    t_sample             r_sr;
    logic [GAIN_W-1:0]   r_gl;
    logic [GAIN_W-1:0]   r_gr;
    logic [PHASE_W-1:0]  r_step;
    logic signed [PROD_W-1:0] r_pl;
    logic signed [PROD_W-1:0] r_pr;
    t_sample             r_out_left;
    t_sample             r_out_right;

    function automatic t_sample round_sat(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0]        sum;
        logic signed [SAMPLE_BITS+1:0]   r;
        t_sample                         res;
        sum = p + (PROD_W'(1) <<< 29);
        r   = sum[PROD_W-1:30];
        if ((r[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b000)
                || (r[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b111)) begin
            res = r[SAMPLE_BITS-1:0];
        end else if (r[SAMPLE_BITS+1]) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sl   <= i_sample_left;
            r_sr   <= r_mono ? i_sample_left : i_sample_right;
            r_gl   <= gl_full[GAIN_W-1:0];
            r_gr   <= gr_full[GAIN_W-1:0];
            r_step <= step_c[PHASE_W-1:0];
        end
        if (i_cmd.mult) begin
            r_pl <= $signed(r_sl) * $signed({1'b0, r_gl});
            r_pr <= $signed(r_sr) * $signed({1'b0, r_gr});
        end
        if (i_cmd.round) begin
            r_out_left  <= round_sat(r_pl);
            r_out_right <= round_sat(r_pr);
        end
    end

    // Phase accumulator and output run counter
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [CNT_W-1:0]   r_cnt;
    logic [PHASE_W-1:0] phase_sum;
    logic               sum_ge_one;

    always_comb begin
        phase_sum  = r_phase + r_step;
        sum_ge_one = (phase_sum >= PHASE_ONE);
        o_status.phase_ge_one = (r_phase >= PHASE_ONE);
        o_status.last         = sum_ge_one || (r_cnt == CNT_LAST);
        n_phase = r_phase;
        if (i_cmd.drop) begin
            n_phase = r_phase - PHASE_ONE;
        end else if (i_cmd.adv) begin
            if (!o_status.last) begin
                n_phase = phase_sum;
            end else if (sum_ge_one) begin
                n_phase = phase_sum - PHASE_ONE;
            end else begin
                // run cut short by the count limit
                n_phase = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.adv) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_out_left  = r_out_left;
    assign o_out_right = r_out_right;

endmodule

// ----- hdl/nearest_resampler_pan_gain_unit.sv -----
// Flow: an accepted input frame is multiplied (MULT) and rounded (ROUND), then EMIT presents its
// n = 0..64 output frames; a new input frame is accepted only in idle, after the run ends.
// Output frames leave one per cycle while the output side takes them (i_out_ready); the emit loop
// of the controller and the two-stage gain multiply shape this flow.
// Reset (synchronous, active low): configuration registers return to their defaults
// (unity step, unity volume, center pan, stereo), phase clears, controller idles.
module nearest_resampler_pan_gain_unit
    import nrpg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_sample                i_sample_left,
    input  t_sample                i_sample_right,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_sample                o_out_left,
    output t_sample                o_out_right,
    output logic                   o_run_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    nrpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    nrpg_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_write    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample_left  (i_sample_left),
        .i_sample_right (i_sample_right),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_left     (o_out_left),
        .o_out_right    (o_out_right)
    );

    assign o_run_last = status.last;

endmodule
